// ===== rtl/core/mgsv_pkg.sv =====
// Shared constants, types and elaboration-time table builders for the sine voice.
package mgsv_pkg;

  localparam int SAMPLE_RATE    = 44100;
  localparam int PHASE_BITS     = 32;
  localparam int SINE_ADDR_BITS = 10;
  localparam int SAMPLE_BITS    = 16;
  localparam int AMP_BITS       = 15;
  localparam int NOTE_BITS      = 7;
  localparam int HELD_BITS      = 8;
  localparam int NUM_NOTES      = 1 << NOTE_BITS;
  localparam int SINE_SIZE      = 1 << SINE_ADDR_BITS;
  localparam int QUARTER_BITS   = SINE_ADDR_BITS - 2;
  localparam int QUARTER        = 1 << QUARTER_BITS;
  localparam int FULL_SCALE     = (1 << (SAMPLE_BITS - 1)) - 1;
  localparam int PROD_BITS      = SAMPLE_BITS + AMP_BITS;

  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_PTR_BITS = 2;
  localparam int QUEUE_LVL_BITS = QUEUE_PTR_BITS + 1;

  localparam logic [AMP_BITS-1:0]  AMP_RESET = AMP_BITS'(13107);
  localparam logic [HELD_BITS-1:0] NO_NOTE   = '1;

  localparam logic [63:0] DEC18       = 64'd1000000000000000000;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_NOTE_ON  = 2'd1,
    OP_NOTE_OFF = 2'd2,
    OP_UNUSED   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_NOTE_ON  = 2'd1,
    CMD_NOTE_OFF = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t              kind;
    logic [NOTE_BITS-1:0]   note;
    logic [PHASE_BITS-1:0]  step;
  } cmd_t;

  typedef struct packed {
    logic                      full;
    logic                      empty;
    logic [QUEUE_LVL_BITS-1:0] level;
  } qstat_t;

  typedef logic [NUM_NOTES-1:0][PHASE_BITS-1:0] step_rom_t;
  typedef logic [SINE_SIZE-1:0][SAMPLE_BITS-1:0] sine_rom_t;

  // 2^(s/12) scaled by 10^18 and truncated.
  function automatic logic [63:0] semitone_ratio(input int s);
    logic [63:0] r;
    case (s)
      0:       r = 64'd1000000000000000000;
      1:       r = 64'd1059463094359295264;
      2:       r = 64'd1122462048309372981;
      3:       r = 64'd1189207115002721066;
      4:       r = 64'd1259921049894873164;
      5:       r = 64'd1334839854170034364;
      6:       r = 64'd1414213562373095048;
      7:       r = 64'd1498307076876681498;
      8:       r = 64'd1587401051968199474;
      9:       r = 64'd1681792830507429086;
      10:      r = 64'd1781797436280678609;
      default: r = 64'd1887748625363386993;
    endcase
    return r;
  endfunction

  // Restoring long division, used only while building the tables.
  function automatic logic [127:0] udiv128(input logic [127:0] n, input logic [127:0] d);
    logic [127:0] rem;
    logic [127:0] q;
    rem = '0;
    q   = '0;
    for (int b = 127; b >= 0; b--) begin
      rem = {rem[126:0], n[b]};
      if (rem >= d) begin
        rem  = rem - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic step_rom_t build_step_rom();
    step_rom_t    rom;
    logic [127:0] den;
    logic [127:0] num;
    int           t;
    int           shift;
    den = 128'(SAMPLE_RATE) * 128'(DEC18);
    for (int n = 0; n < NUM_NOTES; n++) begin
      t     = n + 3;
      shift = PHASE_BITS + t / 12 - 6;
      num   = (128'(440) * 128'(semitone_ratio(t % 12))) << shift;
      num   = (num << 1) + den;
      rom[n] = PHASE_BITS'(udiv128(num, den << 1));
    end
    return rom;
  endfunction

  // sin(pi/2 * q / QUARTER) in Q30 from a truncated Taylor series.
  function automatic logic [63:0] quarter_sine_q30(input logic [63:0] q);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    x    = (q * HALF_PI_Q30) >> QUARTER_BITS;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    for (int k = 1; k <= 8; k++) begin
      term = 64'(udiv128(128'((term * x2) >> 30), 128'((2 * k) * (2 * k + 1))));
      if ((k & 1) != 0) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    return sum[63] ? 64'd0 : 64'(sum);
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    int          quad;
    int          qpos;
    int          arg;
    logic [63:0] s;
    logic [63:0] mag;
    for (int i = 0; i < SINE_SIZE; i++) begin
      quad = i >> QUARTER_BITS;
      qpos = i & (QUARTER - 1);
      arg  = ((quad & 1) != 0) ? (QUARTER - qpos) : qpos;
      s    = quarter_sine_q30(64'(arg));
      mag  = (s * 64'(FULL_SCALE) + (64'd1 << 29)) >> 30;
      if (mag > 64'(FULL_SCALE)) begin
        mag = 64'(FULL_SCALE);
      end
      rom[i] = ((quad & 2) != 0) ? SAMPLE_BITS'(64'd0 - mag) : SAMPLE_BITS'(mag);
    end
    return rom;
  endfunction

endpackage

// ===== rtl/core/mgsv_front.sv =====
// Front end: accepts input transactions, decodes the opcode and looks up the note step.
module mgsv_front (
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_opcode,
  input  logic [mgsv_pkg::NOTE_BITS-1:0] in_note,
  input  mgsv_pkg::qstat_t              q_stat,
  output logic                          q_push,
  output mgsv_pkg::cmd_t                q_cmd
);
  import mgsv_pkg::*;

  localparam step_rom_t STEP_ROM = build_step_rom();

  logic    accept;
  opcode_t op;
  logic    keep;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;
  assign op       = opcode_t'(in_opcode);

  always_comb begin
    keep       = 1'b1;
    q_cmd.kind = CMD_TICK;
    q_cmd.note = in_note;
    q_cmd.step = STEP_ROM[in_note];
    unique case (op)
      OP_TICK:     q_cmd.kind = CMD_TICK;
      OP_NOTE_ON:  q_cmd.kind = CMD_NOTE_ON;
      OP_NOTE_OFF: q_cmd.kind = CMD_NOTE_OFF;
      default:     keep = 1'b0;
    endcase
  end

  // The unused opcode is consumed here and never reaches the back end.
  assign q_push = accept && keep;

endmodule

// ===== rtl/core/mgsv_queue.sv =====
// Small command queue between the front end and the back end.
module mgsv_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  mgsv_pkg::cmd_t   push_cmd,
  input  logic             pop,
  output mgsv_pkg::cmd_t   head,
  output mgsv_pkg::qstat_t stat
);
  import mgsv_pkg::*;

  cmd_t                      mem_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_LVL_BITS-1:0] level_r, level_nxt;
  logic                      do_push;
  logic                      do_pop;

  assign stat.level = level_r;
  assign stat.full  = (level_r == QUEUE_LVL_BITS'(QUEUE_DEPTH));
  assign stat.empty = (level_r == '0);
  assign head       = mem_r[rd_ptr_r];

  assign do_push = push && !stat.full;
  assign do_pop  = pop && !stat.empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    level_nxt  = level_r;
    if (do_push && !do_pop) begin
      level_nxt = level_r + 1'b1;
    end else if (do_pop && !do_push) begin
      level_nxt = level_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== rtl/core/mgsv_back.sv =====
// Back end: voice state, phase accumulator, sine lookup, gain and output register.
module mgsv_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [mgsv_pkg::AMP_BITS-1:0]     cfg_wr_data,
  input  mgsv_pkg::qstat_t                  q_stat,
  input  mgsv_pkg::cmd_t                    q_head,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [mgsv_pkg::SAMPLE_BITS-1:0] out_sample_out
);
  import mgsv_pkg::*;

  localparam sine_rom_t SINE_ROM = build_sine_rom();
  localparam int RND_BITS = PROD_BITS - AMP_BITS + 1;
  localparam int VAL_BITS = RND_BITS + 1;
  localparam logic signed [VAL_BITS-1:0] SAT_HI = VAL_BITS'(FULL_SCALE);
  localparam logic signed [VAL_BITS-1:0] SAT_LO = VAL_BITS'(-FULL_SCALE - 1);

  logic [AMP_BITS-1:0]   amplitude_r;
  logic [PHASE_BITS-1:0] phase_acc_r, phase_acc_nxt;
  logic [PHASE_BITS-1:0] phase_step_r, phase_step_nxt;
  logic [HELD_BITS-1:0]  held_note_r, held_note_nxt;
  logic                  gate_open_r, gate_open_nxt;

  logic                   adv;
  logic                   s1_valid_r, s1_gate_r;
  logic [SAMPLE_BITS-1:0] sine_r;
  logic                   s2_valid_r, s2_gate_r, s2_neg_r;
  logic [PROD_BITS-1:0]   s2_prod_r;
  logic                   out_valid_r;
  logic [SAMPLE_BITS-1:0] out_sample_r;

  logic [SAMPLE_BITS-1:0]     sine_abs;
  logic [PROD_BITS:0]         rnd_sum;
  logic [RND_BITS-1:0]        rnd_mag;
  logic signed [VAL_BITS-1:0] rnd_val;
  logic signed [VAL_BITS-1:0] sat_val;
  logic [SAMPLE_BITS-1:0]     sample_nxt;

  // The whole pipeline moves together whenever the output register can take a sample.
  assign adv   = !out_valid_r || !out_stall;
  assign q_pop = adv && !q_stat.empty;

  always_comb begin
    phase_acc_nxt  = phase_acc_r;
    phase_step_nxt = phase_step_r;
    held_note_nxt  = held_note_r;
    gate_open_nxt  = gate_open_r;
    if (q_pop) begin
      unique case (q_head.kind)
        CMD_NOTE_ON: begin
          held_note_nxt  = HELD_BITS'(q_head.note);
          phase_step_nxt = q_head.step;
          phase_acc_nxt  = '0;
          gate_open_nxt  = 1'b1;
        end
        CMD_NOTE_OFF: begin
          if (HELD_BITS'(q_head.note) == held_note_r) begin
            gate_open_nxt = 1'b0;
          end
        end
        default: begin
          if (gate_open_r) begin
            phase_acc_nxt = phase_acc_r + phase_step_r;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amplitude_r  <= AMP_RESET;
      phase_acc_r  <= '0;
      phase_step_r <= '0;
      held_note_r  <= NO_NOTE;
      gate_open_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        amplitude_r <= cfg_wr_data;
      end
      phase_acc_r  <= phase_acc_nxt;
      phase_step_r <= phase_step_nxt;
      held_note_r  <= held_note_nxt;
      gate_open_r  <= gate_open_nxt;
    end
  end

  // Sine table read with a registered output; address is the top phase bits.
  always_ff @(posedge clk) begin
    if (adv) begin
      sine_r <= SINE_ROM[phase_acc_r[PHASE_BITS-1 -: SINE_ADDR_BITS]];
    end
  end

  assign sine_abs = sine_r[SAMPLE_BITS-1] ? ('0 - sine_r) : sine_r;

  always_comb begin
    rnd_sum = {1'b0, s2_prod_r} + (PROD_BITS + 1)'(1 << (AMP_BITS - 1));
    rnd_mag = rnd_sum[PROD_BITS:AMP_BITS];
    rnd_val = $signed({1'b0, rnd_mag});
    if (s2_neg_r) begin
      rnd_val = -rnd_val;
    end
    sat_val = rnd_val;
    if (rnd_val > SAT_HI) begin
      sat_val = SAT_HI;
    end else if (rnd_val < SAT_LO) begin
      sat_val = SAT_LO;
    end
    sample_nxt = s2_gate_r ? SAMPLE_BITS'(sat_val) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= q_pop && (q_head.kind == CMD_TICK);
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_gate_r    <= gate_open_r;
      s2_gate_r    <= s1_gate_r;
      s2_neg_r     <= sine_r[SAMPLE_BITS-1];
      s2_prod_r    <= PROD_BITS'(sine_abs) * PROD_BITS'(amplitude_r);
      out_sample_r <= sample_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = $signed(out_sample_r);

endmodule

// ===== rtl/core/midi_gated_sine_voice.sv =====
// Top level of the note-driven gated sine voice.
// An accepted sample tick passes the command queue, sine register and product register to out_*.
// Throughput: one transaction per cycle in, and one sample per cycle out while ticks flow and neither stalls.
// The four-entry command queue fills only while the output stalls; then in_stall rises.
// Reset (rst_n low, synchronous) clears the queue, the pipeline valids and the voice state,
// and restores the default gain. No clearing pass is needed.
module midi_gated_sine_voice (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_wr_en,
  input  logic [mgsv_pkg::AMP_BITS-1:0]           cfg_wr_data,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic [1:0]                              in_opcode,
  input  logic [mgsv_pkg::NOTE_BITS-1:0]          in_note,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [mgsv_pkg::SAMPLE_BITS-1:0] out_sample_out
);
  import mgsv_pkg::*;

  qstat_t q_stat;
  logic   q_push;
  logic   q_pop;
  cmd_t   q_cmd;
  cmd_t   q_head;

  mgsv_front u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_opcode (in_opcode),
    .in_note   (in_note),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_cmd     (q_cmd)
  );

  mgsv_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .stat     (q_stat)
  );

  mgsv_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .q_stat         (q_stat),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample_out (out_sample_out)
  );

`ifndef NO_ASSERTIONS
  a_queue_level: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.level <= QUEUE_LVL_BITS'(QUEUE_DEPTH))
    else $error("command queue level above its depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_stat.full))
    else $error("front end pushed into a full queue");

  a_no_pop_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> !q_pop)
    else $error("back end consumed a command while the output was stalled");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");
`endif

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the note-driven gated sine voice.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mgsv_pkg::*;

  // One row of the directed stimulus: either a gain write or one input transaction.
  typedef struct packed {
    logic                  is_gain;
    opcode_t               op;
    logic [NOTE_BITS-1:0]  note;
    logic [AMP_BITS-1:0]   gain;
    logic                  typed;
    logic signed [15:0]    want;
  } dir_row_t;

  localparam int DIR_ROWS       = 28;
  localparam int PHASES         = 5;
  localparam int ITEMS_PER_PHASE = 128;
  localparam int MAX_GAP        = 18;
  localparam int LONG_HOLD      = 90;
  localparam int SETTLE_CYCLES  = 8;

  // 2^(s/12) scaled by 10^18 and truncated, index 0 is the last entry.
  localparam logic [11:0][63:0] SEMI_X18 = {
    64'd1887748625363386993, 64'd1781797436280678609, 64'd1681792830507429086,
    64'd1587401051968199474, 64'd1498307076876681498, 64'd1414213562373095048,
    64'd1334839854170034364, 64'd1259921049894873164, 64'd1189207115002721066,
    64'd1122462048309372981, 64'd1059463094359295264, 64'd1000000000000000000
  };

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_wr_en = 1'b0;
  logic [AMP_BITS-1:0]           cfg_wr_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [1:0]                    in_opcode = 2'd0;
  logic [NOTE_BITS-1:0]          in_note = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic signed [SAMPLE_BITS-1:0] out_sample_out;

  // Voice model state.
  logic [PHASE_BITS-1:0]         step_tbl [NUM_NOTES];
  logic signed [SAMPLE_BITS-1:0] sine_tbl [SINE_SIZE];
  logic [PHASE_BITS-1:0]         v_phase;
  logic [PHASE_BITS-1:0]         v_step;
  logic [HELD_BITS-1:0]          v_held;
  logic                          v_gate;
  logic [AMP_BITS-1:0]           v_gain;

  logic signed [SAMPLE_BITS-1:0] sample_due [$];

  int  mismatches = 0;
  int  n_sent = 0;
  int  n_on = 0;
  int  n_off = 0;
  int  gain_writes = 0;
  int  rx_count = 0;
  int  rx_gap = 0;
  int  rx_hold = 0;
  bit  rx_burst = 1'b0;
  bit  hold_served = 1'b0;
  bit  hold_req = 1'b0;
  bit  tx_burst = 1'b0;
  int  fast_left = 0;
  logic signed [SAMPLE_BITS-1:0] rx_want;

  dir_row_t dir_tbl [DIR_ROWS] = '{
    '{1'b0, OP_TICK,     7'd0,   15'd0,     1'b1, 16'sd0},
    '{1'b0, OP_NOTE_OFF, 7'd60,  15'd0,     1'b0, 16'sd0},
    '{1'b0, OP_TICK,     7'd127, 15'd0,     1'b1, 16'sd0},
    '{1'b0, OP_UNUSED,   7'd127, 15'd0,     1'b0, 16'sd0},
    '{1'b0, OP_TICK,     7'd0,   15'd0,     1'b1, 16'sd0},
    '{1'b0, OP_NOTE_ON,  7'd69,  15'd0,     1'b0, 16'sd0},
    '{1'b0, OP_TICK,     7'd0,   15'd0,     1'b1, 16'sd0},
    '{1'b0, OP_TICK,     7'd0,   15'd0,     1'b0, 16'sd0},
    '{1'b0, OP_NOTE_OFF, 7'd70,  15'd0,     1'b0, 16'sd0},
    '{1'b0, OP_TICK,     7'd0,   15'd0,     1'b0, 16'sd0},
    '{1'b0, OP_NOTE_ON,  7'd69,  15'd0,     1'b0, 16'sd0},
    '{1'b0, OP_TICK,     7'd0,   15'd0,     1'b1, 16'sd0},
    '{1'b0, OP_TICK,     7'd0,   15'd0,     1'b0, 16'sd0},
    '{1'b0, OP_NOTE_OFF, 7'd69,  15'd0,     1'b0, 16'sd0},
    '{1'b0, OP_TICK,     7'd0,   15'd0,     1'b1, 16'sd0},
    '{1'b0, OP_NOTE_OFF, 7'd69,  15'd0,     1'b0, 16'sd0},
    '{1'b0, OP_TICK,     7'd0,   15'd0,     1'b1, 16'sd0},
    '{1'b1, OP_TICK,     7'd0,   15'd32767, 1'b0, 16'sd0},
    '{1'b0, OP_NOTE_ON,  7'd0,   15'd0,     1'b0, 16'sd0},
    '{1'b0, OP_TICK,     7'd0,   15'd0,     1'b1, 16'sd0},
    '{1'b0, OP_TICK,     7'd0,   15'd0,     1'b0, 16'sd0},
    '{1'b0, OP_NOTE_ON,  7'd127, 15'd0,     1'b0, 16'sd0},
    '{1'b0, OP_TICK,     7'd0,   15'd0,     1'b1, 16'sd0},
    '{1'b0, OP_TICK,     7'd0,   15'd0,     1'b0, 16'sd0},
    '{1'b0, OP_TICK,     7'd0,   15'd0,     1'b0, 16'sd0},
    '{1'b1, OP_TICK,     7'd0,   15'd0,     1'b0, 16'sd0},
    '{1'b0, OP_NOTE_ON,  7'd64,  15'd0,     1'b0, 16'sd0},
    '{1'b0, OP_TICK,     7'd0,   15'd0,     1'b1, 16'sd0}
  };

  midi_gated_sine_voice dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_note        (in_note),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample_out (out_sample_out)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // sin(pi/2 * q / QUARTER) in Q30, truncated Taylor series.
  function automatic logic [63:0] quarter_sin_q30(input logic [63:0] q);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] acc;
    x    = (q * HALF_PI_Q30) >> QUARTER_BITS;
    x2   = (x * x) >> 30;
    term = x;
    acc  = $signed(x);
    for (int k = 1; k <= 8; k++) begin
      term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        acc = acc - $signed(term);
      end else begin
        acc = acc + $signed(term);
      end
    end
    return (acc < 0) ? 64'd0 : 64'(acc);
  endfunction

  function automatic void build_voice_tables();
    logic [127:0]           den;
    logic [127:0]           num;
    int                     t;
    int                     shift;
    logic [1:0]             quad;
    int                     qpos;
    logic [63:0]            mag;
    logic [SAMPLE_BITS-1:0] mag16;
    den = 128'(SAMPLE_RATE) * 128'(DEC18);
    for (int n = 0; n < NUM_NOTES; n++) begin
      t     = n + 3;
      shift = PHASE_BITS + t / 12 - 6;
      num   = (128'd440 * 128'(SEMI_X18[t % 12])) << shift;
      num   = (num << 1) + den;
      step_tbl[n] = PHASE_BITS'(num / (den << 1));
    end
    for (int i = 0; i < SINE_SIZE; i++) begin
      quad = 2'(i >> QUARTER_BITS);
      qpos = i % QUARTER;
      mag  = quarter_sin_q30(64'(quad[0] ? QUARTER - qpos : qpos));
      mag  = (mag * 64'(FULL_SCALE) + (64'd1 << 29)) >> 30;
      if (mag > 64'(FULL_SCALE)) begin
        mag = 64'(FULL_SCALE);
      end
      mag16 = SAMPLE_BITS'(mag);
      sine_tbl[i] = quad[1] ? -$signed(mag16) : $signed(mag16);
    end
  endfunction

  // Advances the voice by one transaction; returns 1 when a tick produces a sample.
  function automatic bit voice_step(input opcode_t op, input logic [NOTE_BITS-1:0] nt,
                                    output logic signed [SAMPLE_BITS-1:0] smp);
    logic signed [SAMPLE_BITS-1:0] s;
    logic [SAMPLE_BITS-1:0]        mag;
    logic [31:0]                   prod;
    int                            val;
    smp = '0;
    case (op)
      OP_NOTE_ON: begin
        v_held  = HELD_BITS'(nt);
        v_step  = step_tbl[nt];
        v_phase = '0;
        v_gate  = 1'b1;
        return 1'b0;
      end
      OP_NOTE_OFF: begin
        if (HELD_BITS'(nt) == v_held) begin
          v_gate = 1'b0;
        end
        return 1'b0;
      end
      OP_TICK: begin
        val = 0;
        if (v_gate) begin
          s    = sine_tbl[v_phase[PHASE_BITS-1 -: SINE_ADDR_BITS]];
          mag  = (s < 0) ? -s : s;
          prod = (32'(mag) * 32'(v_gain) + 32'd16384) >> 15;
          val  = (s < 0) ? -int'(prod) : int'(prod);
          if (val > FULL_SCALE) begin
            val = FULL_SCALE;
          end
          if (val < -FULL_SCALE - 1) begin
            val = -FULL_SCALE - 1;
          end
          v_phase = v_phase + v_step;
        end
        smp = SAMPLE_BITS'(val);
        return 1'b1;
      end
      default: begin
        return 1'b0;
      end
    endcase
  endfunction

  // Offers one transaction after a random gap and records its effect once accepted.
  task automatic send_item(input opcode_t op, input logic [NOTE_BITS-1:0] nt,
                           input bit typed, input logic signed [SAMPLE_BITS-1:0] want);
    int                            gap;
    logic signed [SAMPLE_BITS-1:0] smp;
    if (n_sent % 32 == 0) begin
      tx_burst = ($urandom_range(0, 4) == 0);
    end
    gap = (tx_burst || fast_left > 0) ? 0 : $urandom_range(0, MAX_GAP);
    if (fast_left > 0) begin
      fast_left--;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_note   <= nt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
    if (op == OP_NOTE_ON) n_on++;
    if (op == OP_NOTE_OFF) n_off++;
    if (voice_step(op, nt, smp)) begin
      sample_due.insert(sample_due.size(), typed ? want : smp);
    end
  endtask

  // Stops offering and waits until every expected sample has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sample_due.size() != 0) @(posedge clk);
  endtask

  task automatic set_gain(input logic [AMP_BITS-1:0] g);
    wait_drained();
    // A trailing note event may still be in flight behind the last sample.
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= g;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    v_gain = g;
    gain_writes++;
  endtask

  task automatic send_random(output bit counted);
    int                   pick;
    opcode_t              op;
    logic [NOTE_BITS-1:0] nt;
    pick    = $urandom_range(0, 99);
    nt      = NOTE_BITS'($urandom);
    counted = 1'b1;
    if (pick < 74) begin
      op = OP_TICK;
    end else if (pick < 86) begin
      op = OP_NOTE_ON;
    end else if (pick < 96) begin
      op = OP_NOTE_OFF;
      if (pick < 92 && v_held != NO_NOTE) begin
        nt = v_held[NOTE_BITS-1:0];
      end
      counted = (HELD_BITS'(nt) == v_held);
    end else begin
      op      = OP_UNUSED;
      counted = 1'b0;
    end
    send_item(op, nt, 1'b0, '0);
  endtask

  // Result side: checks each accepted sample and drives out_stall.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        rx_count++;
        if (rx_count % 32 == 0) begin
          rx_burst = ($urandom_range(0, 3) == 0);
        end
        if (sample_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("sample %0d: got %0d with nothing expected", rx_count, out_sample_out);
          end
        end else begin
          rx_want = sample_due.pop_front();
          if (rx_want !== out_sample_out) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("sample %0d: expected %0d, got %0d", rx_count, rx_want, out_sample_out);
            end
          end
        end
        rx_gap = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (hold_req && !hold_served) begin
        hold_served = 1'b1;
        rx_hold     = LONG_HOLD;
      end
      if (rx_hold > 0) begin
        out_stall <= 1'b1;
        rx_hold--;
      end else if (rx_gap > 0) begin
        out_stall <= 1'b1;
        rx_gap--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    logic [AMP_BITS-1:0] phase_gain [PHASES];
    int                  done;
    bit                  counted;
    build_voice_tables();
    v_phase = '0;
    v_step  = '0;
    v_held  = NO_NOTE;
    v_gate  = 1'b0;
    v_gain  = AMP_RESET;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_tbl[i].is_gain) begin
        set_gain(dir_tbl[i].gain);
      end else begin
        send_item(dir_tbl[i].op, dir_tbl[i].note, dir_tbl[i].typed, dir_tbl[i].want);
      end
    end

    phase_gain[0] = AMP_BITS'($urandom_range(1, 32766));
    phase_gain[1] = '1;
    phase_gain[2] = AMP_RESET;
    phase_gain[3] = AMP_BITS'($urandom);
    phase_gain[4] = AMP_BITS'(1);
    for (int p = 0; p < PHASES; p++) begin
      set_gain(phase_gain[p]);
      done = 0;
      while (done < ITEMS_PER_PHASE) begin
        // Hold the output for a long stretch while the input keeps coming back to back.
        if (p == 1 && done == 20 && !hold_req) begin
          hold_req  <= 1'b1;
          fast_left = 40;
        end
        if (p == 3 && done == 70) begin
          wait_drained();
        end
        send_random(counted);
        if (counted) done++;
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    mismatches += sample_due.size();
    $display("Sent %0d transactions (%0d note-ons, %0d note-offs), checked %0d samples.",
             n_sent, n_on, n_off, rx_count);
    $display("Gain was written %0d times, including both extremes.", gain_writes);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
